// ===== rtl/core/sd_pkg.sv =====
// ----------------------------------------------------------------------------
// sd_pkg - segment distance shared definitions
// Widths, register indexes and the word types carried along the cell chains.
// ----------------------------------------------------------------------------
package sd_pkg;

    localparam int COORD_W     = 16;
    localparam int FRAC_W      = 8;
    localparam int IN_W        = 16;
    localparam int WEIGHT_W    = 16;
    localparam int WEIGHT_FRAC = 12;
    localparam int DIST_W      = 48;
    localparam int NLANE       = 4;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SUB_W   = PROD_W + 2;
    localparam int NUM_W   = PROD_W;
    localparam int HALF_W  = NUM_W / 2;
    localparam int SQ_W    = 2 * NUM_W;
    localparam int QUO_W   = NUM_W + 2 * FRAC_W;
    localparam int ROOT_W  = QUO_W / 2;
    localparam int DREM_W  = (NUM_W > ROOT_W + 1) ? NUM_W : ROOT_W + 1;
    localparam int PSUM_W  = 2 * ROOT_W + 1;
    localparam int MIX_W   = WEIGHT_W + ROOT_W;
    localparam int TOT_W   = MIX_W + 2;
    localparam int EXT_W   = (TOT_W > DIST_W + 1) ? TOT_W : DIST_W + 1;
    localparam int LAT_MID = QUO_W + 2 * ROOT_W + 2;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_WPERP = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WPAR  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_WANG  = REG_IDX_W'(2);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);
    localparam logic [DIST_W-1:0]   DIST_MAX     = '1;

    // restoring divider word: partial remainder, divisor, dividend bits / quotient
    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [DREM_W-1:0] den;
        logic [QUO_W-1:0]  sh;
    } sd_div_t;

    // digit-by-digit square root word
    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [QUO_W-1:0]  sh;
    } sd_sqrt_t;

    typedef struct packed {
        logic [ROOT_W-1:0] par;
        logic [ROOT_W-1:0] ang;
        logic              zero;
    } sd_side_t;

endpackage

// ===== rtl/core/sd_div_cell.sv =====
// ----------------------------------------------------------------------------
// sd_div_cell - one restoring division step
// Brings down one dividend bit, trial subtracts the divisor, shifts in the
// quotient bit and hands the word to the next cell.
// ----------------------------------------------------------------------------
module sd_div_cell (
    input  logic            clk,
    input  sd_pkg::sd_div_t din,
    output sd_pkg::sd_div_t dout
);
    import sd_pkg::*;

    logic [DREM_W:0] trial;
    logic [DREM_W:0] diff;
    logic            ge;
    sd_div_t         cell_next;
    sd_div_t         cell_reg;

    assign trial = {din.rem, din.sh[QUO_W-1]};
    assign ge    = trial >= {1'b0, din.den};
    assign diff  = trial - {1'b0, din.den};

    always_comb
    begin
        cell_next.rem = ge ? diff[DREM_W-1:0] : trial[DREM_W-1:0];
        cell_next.den = din.den;
        cell_next.sh  = {din.sh[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/core/sd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sd_sqrt_cell - one square root digit
// Takes two radicand bits, tries root*4+1 against the remainder and appends
// one root bit.
// ----------------------------------------------------------------------------
module sd_sqrt_cell (
    input  logic             clk,
    input  sd_pkg::sd_sqrt_t din,
    output sd_pkg::sd_sqrt_t dout
);
    import sd_pkg::*;

    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;
    sd_sqrt_t          cell_next;
    sd_sqrt_t          cell_reg;

    assign t     = {din.rem, din.sh[QUO_W-1 -: 2]};
    assign trial = {2'b00, din.root, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_comb
    begin
        cell_next.rem  = ge ? diff[ROOT_W+1:0] : t[ROOT_W+1:0];
        cell_next.root = {din.root[ROOT_W-2:0], ge};
        cell_next.sh   = {din.sh[QUO_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/core/sd_front.sv =====
// ----------------------------------------------------------------------------
// sd_front - geometry front end
// Differences, products, dot and cross terms, minimum search and the squared
// numerators; emits one division word per lane (da, db, parallel, angle).
// ----------------------------------------------------------------------------
module sd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  logic [sd_pkg::IN_W-1:0] seg_a_start_x,
    input  logic [sd_pkg::IN_W-1:0] seg_a_start_y,
    input  logic [sd_pkg::IN_W-1:0] seg_a_end_x,
    input  logic [sd_pkg::IN_W-1:0] seg_a_end_y,
    input  logic [sd_pkg::IN_W-1:0] seg_b_start_x,
    input  logic [sd_pkg::IN_W-1:0] seg_b_start_y,
    input  logic [sd_pkg::IN_W-1:0] seg_b_end_x,
    input  logic [sd_pkg::IN_W-1:0] seg_b_end_y,
    output logic                   out_vld,
    output sd_pkg::sd_div_t        lane_o [sd_pkg::NLANE]
);
    import sd_pkg::*;

    localparam int FRONT_LAT = 7;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        logic             direct;
    } lane_t;

    function automatic logic [SUB_W-1:0] mag_f(input logic signed [SUB_W-1:0] v);
        logic [SUB_W-1:0] u;
        u = v;
        return v[SUB_W-1] ? (~u + 1'b1) : u;
    endfunction

    logic [FRONT_LAT-1:0] vld_reg;

    logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    // stage 1
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, w1x_reg, w1y_reg;
    logic signed [DIFF_W-1:0] w2x_reg, w2y_reg, vx_reg, vy_reg;
    // stage 2
    logic signed [PROD_W-1:0] dxx_reg, dyy_reg, w1xx_reg, w1yy_reg;
    logic signed [PROD_W-1:0] w2xx_reg, w2yy_reg, vxx_reg, vyy_reg;
    logic signed [PROD_W-1:0] c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    logic signed [PROD_W-1:0] d1a_reg, d1b_reg, d2a_reg, d2b_reg;
    logic signed [PROD_W-1:0] caa_reg, cab_reg;
    // stage 3
    logic signed [SUM_W-1:0] l2_reg, cr1_reg, cr2_reg, dt1_reg, dt2_reg, cra_reg;
    logic [NUM_W-1:0]        w1sq_reg, w2sq_reg, v2_reg;
    // stage 4
    logic [NUM_W-1:0] l2n_reg, w1sq4_reg, w2sq4_reg, v24_reg;
    logic [NUM_W-1:0] mc1_reg, mc2_reg, mca_reg;
    logic [SUB_W-1:0] md1_reg, md1b_reg, md2_reg, md2b_reg;
    logic             l2z_reg, v2z_reg;
    // stage 5
    logic [SUB_W-1:0] m01, m23, m_wide;
    logic [NUM_W-1:0] m_min;
    lane_t            lane_next [NLANE];
    lane_t            lane_reg  [NLANE];
    // stage 6
    lane_t             lane6_reg [NLANE];
    logic [NUM_W-1:0]  hh_reg [NLANE];
    logic [NUM_W-1:0]  hl_reg [NLANE];
    logic [NUM_W-1:0]  ll_reg [NLANE];
    // stage 7
    logic [SQ_W-1:0]   sq_val [NLANE];
    sd_div_t           out_reg [NLANE];

    assign ax0 = COORD_W'(seg_a_start_x);
    assign ay0 = COORD_W'(seg_a_start_y);
    assign ax1 = COORD_W'(seg_a_end_x);
    assign ay1 = COORD_W'(seg_a_end_y);
    assign bx0 = COORD_W'(seg_b_start_x);
    assign by0 = COORD_W'(seg_b_start_y);
    assign bx1 = COORD_W'(seg_b_end_x);
    assign by1 = COORD_W'(seg_b_end_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[FRONT_LAT-1];

    always_ff @(posedge clk)
    begin
        dx_reg  <= DIFF_W'(ax1) - DIFF_W'(ax0);
        dy_reg  <= DIFF_W'(ay1) - DIFF_W'(ay0);
        w1x_reg <= DIFF_W'(bx0) - DIFF_W'(ax0);
        w1y_reg <= DIFF_W'(by0) - DIFF_W'(ay0);
        w2x_reg <= DIFF_W'(bx1) - DIFF_W'(ax0);
        w2y_reg <= DIFF_W'(by1) - DIFF_W'(ay0);
        vx_reg  <= DIFF_W'(bx1) - DIFF_W'(bx0);
        vy_reg  <= DIFF_W'(by1) - DIFF_W'(by0);

        dxx_reg  <= dx_reg * dx_reg;
        dyy_reg  <= dy_reg * dy_reg;
        w1xx_reg <= w1x_reg * w1x_reg;
        w1yy_reg <= w1y_reg * w1y_reg;
        w2xx_reg <= w2x_reg * w2x_reg;
        w2yy_reg <= w2y_reg * w2y_reg;
        vxx_reg  <= vx_reg * vx_reg;
        vyy_reg  <= vy_reg * vy_reg;
        c1a_reg  <= w1x_reg * dy_reg;
        c1b_reg  <= w1y_reg * dx_reg;
        c2a_reg  <= w2x_reg * dy_reg;
        c2b_reg  <= w2y_reg * dx_reg;
        d1a_reg  <= w1x_reg * dx_reg;
        d1b_reg  <= w1y_reg * dy_reg;
        d2a_reg  <= w2x_reg * dx_reg;
        d2b_reg  <= w2y_reg * dy_reg;
        caa_reg  <= dx_reg * vy_reg;
        cab_reg  <= dy_reg * vx_reg;

        l2_reg   <= SUM_W'(dxx_reg) + SUM_W'(dyy_reg);
        cr1_reg  <= SUM_W'(c1a_reg) - SUM_W'(c1b_reg);
        cr2_reg  <= SUM_W'(c2a_reg) - SUM_W'(c2b_reg);
        dt1_reg  <= SUM_W'(d1a_reg) + SUM_W'(d1b_reg);
        dt2_reg  <= SUM_W'(d2a_reg) + SUM_W'(d2b_reg);
        cra_reg  <= SUM_W'(caa_reg) - SUM_W'(cab_reg);
        w1sq_reg <= NUM_W'(SUM_W'(w1xx_reg) + SUM_W'(w1yy_reg));
        w2sq_reg <= NUM_W'(SUM_W'(w2xx_reg) + SUM_W'(w2yy_reg));
        v2_reg   <= NUM_W'(SUM_W'(vxx_reg) + SUM_W'(vyy_reg));

        l2n_reg   <= NUM_W'(l2_reg);
        l2z_reg   <= l2_reg == '0;
        v2z_reg   <= v2_reg == '0;
        w1sq4_reg <= w1sq_reg;
        w2sq4_reg <= w2sq_reg;
        v24_reg   <= v2_reg;
        mc1_reg   <= NUM_W'(mag_f(SUB_W'(cr1_reg)));
        mc2_reg   <= NUM_W'(mag_f(SUB_W'(cr2_reg)));
        mca_reg   <= NUM_W'(mag_f(SUB_W'(cra_reg)));
        md1_reg   <= mag_f(SUB_W'(dt1_reg));
        md1b_reg  <= mag_f(SUB_W'(l2_reg) - SUB_W'(dt1_reg));
        md2_reg   <= mag_f(SUB_W'(dt2_reg));
        md2b_reg  <= mag_f(SUB_W'(l2_reg) - SUB_W'(dt2_reg));
    end

    // the minimum never exceeds |dot1|, so it fits the numerator width
    assign m01    = (md1b_reg < md1_reg) ? md1b_reg : md1_reg;
    assign m23    = (md2b_reg < md2_reg) ? md2b_reg : md2_reg;
    assign m_wide = (m23 < m01) ? m23 : m01;
    assign m_min  = NUM_W'(m_wide);

    // degenerate cases go through the divider as value / 1
    always_comb
    begin
        if (l2z_reg)
        begin
            lane_next[0] = '{num: w1sq4_reg, den: NUM_W'(1), direct: 1'b1};
            lane_next[1] = '{num: w2sq4_reg, den: NUM_W'(1), direct: 1'b1};
            lane_next[2] = '{num: '0, den: NUM_W'(1), direct: 1'b1};
            lane_next[3] = '{num: '0, den: NUM_W'(1), direct: 1'b1};
        end
        else
        begin
            lane_next[0] = '{num: mc1_reg, den: l2n_reg, direct: 1'b0};
            lane_next[1] = '{num: mc2_reg, den: l2n_reg, direct: 1'b0};
            lane_next[2] = '{num: m_min, den: l2n_reg, direct: 1'b0};
            if (v2z_reg)
            begin
                lane_next[3] = '{num: l2n_reg, den: NUM_W'(1), direct: 1'b1};
            end
            else
            begin
                lane_next[3] = '{num: mca_reg, den: v24_reg, direct: 1'b0};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            if (lane6_reg[i].direct)
            begin
                sq_val[i] = SQ_W'(lane6_reg[i].num);
            end
            else
            begin
                sq_val[i] = (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                          + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                          + SQ_W'(ll_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            lane_reg[i]  <= lane_next[i];
            lane6_reg[i] <= lane_reg[i];
            hh_reg[i]    <= lane_reg[i].num[NUM_W-1:HALF_W] * lane_reg[i].num[NUM_W-1:HALF_W];
            hl_reg[i]    <= lane_reg[i].num[NUM_W-1:HALF_W] * lane_reg[i].num[HALF_W-1:0];
            ll_reg[i]    <= lane_reg[i].num[HALF_W-1:0] * lane_reg[i].num[HALF_W-1:0];
            out_reg[i].rem <= DREM_W'(sq_val[i][SQ_W-1:NUM_W]);
            out_reg[i].den <= DREM_W'(lane6_reg[i].den);
            out_reg[i].sh  <= {sq_val[i][NUM_W-1:0], (2 * FRAC_W)'(0)};
        end
    end

    assign lane_o = out_reg;

endmodule

// ===== rtl/core/sd_mix.sv =====
// ----------------------------------------------------------------------------
// sd_mix - weighted sum and saturation
// Three Q4.12 weight products, sum, scale down and clip to the output width.
// ----------------------------------------------------------------------------
module sd_mix (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  logic [sd_pkg::ROOT_W-1:0]   perp,
    input  logic [sd_pkg::ROOT_W-1:0]   par,
    input  logic [sd_pkg::ROOT_W-1:0]   ang,
    input  logic [sd_pkg::WEIGHT_W-1:0] w_perp,
    input  logic [sd_pkg::WEIGHT_W-1:0] w_par,
    input  logic [sd_pkg::WEIGHT_W-1:0] w_ang,
    output logic                        done,
    output logic [sd_pkg::DIST_W-1:0]   distance,
    output logic                        saturated
);
    import sd_pkg::*;

    logic              vld1_reg;
    logic              done_reg;
    logic [MIX_W-1:0]  pp_reg, pq_reg, pa_reg;
    logic [TOT_W-1:0]  sum;
    logic [EXT_W-1:0]  tot;
    logic              sat;
    logic [DIST_W-1:0] dist_reg;
    logic              sat_reg;

    assign sum = TOT_W'(pp_reg) + TOT_W'(pq_reg) + TOT_W'(pa_reg);
    assign tot = EXT_W'(sum >> WEIGHT_FRAC);
    assign sat = tot > EXT_W'(DIST_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            done_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg   <= MIX_W'(w_perp) * MIX_W'(perp);
        pq_reg   <= MIX_W'(w_par) * MIX_W'(par);
        pa_reg   <= MIX_W'(w_ang) * MIX_W'(ang);
        dist_reg <= sat ? DIST_MAX : tot[DIST_W-1:0];
        sat_reg  <= sat;
    end

    assign done      = done_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/core/segment_distance_core.sv =====
// ----------------------------------------------------------------------------
// segment_distance_core - weighted line segment distance
// Pipelined kernel: projection terms, four divide/square-root cell chains,
// a perpendicular divide chain and the weighted sum.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------
//  input    | seg_a_*, seg_b_* (8 x 16 bit signed)      | start & !busy
//  result   | distance (48 bit Q40.8), saturated        | done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata   | APB, pready = 1
//
// One word accepted per clock; busy stays low.
// Each result passes the front end, the divider chain (one quotient bit per
// cell), the square root and perpendicular divide chains (one result bit per
// cell) and the weighted sum.
// Reset clears valid flags and loads all weights with 1.0; no clearing pass.
// The receiver cannot stall: each result shows on done for one cycle.
// ----------------------------------------------------------------------------
module segment_distance_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sd_pkg::IN_W-1:0]     seg_a_start_x,
    input  logic [sd_pkg::IN_W-1:0]     seg_a_start_y,
    input  logic [sd_pkg::IN_W-1:0]     seg_a_end_x,
    input  logic [sd_pkg::IN_W-1:0]     seg_a_end_y,
    input  logic [sd_pkg::IN_W-1:0]     seg_b_start_x,
    input  logic [sd_pkg::IN_W-1:0]     seg_b_start_y,
    input  logic [sd_pkg::IN_W-1:0]     seg_b_end_x,
    input  logic [sd_pkg::IN_W-1:0]     seg_b_end_y,
    output logic                        done,
    output logic [sd_pkg::DIST_W-1:0]   distance,
    output logic                        saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sd_pkg::ADDR_W-1:0]   paddr,
    input  logic [sd_pkg::DATA_W-1:0]   pwdata,
    output logic [sd_pkg::DATA_W-1:0]   prdata,
    output logic                        pready
);
    import sd_pkg::*;

    logic [WEIGHT_W-1:0]  wperp_reg, wpar_reg, wang_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    logic     front_vld;
    sd_div_t  front_lane [NLANE];
    sd_div_t  div_s [NLANE][QUO_W+1];
    sd_sqrt_t sq_s  [NLANE][ROOT_W+1];

    logic [ROOT_W-1:0]   da, db;
    logic [2*ROOT_W-1:0] da2_reg, db2_reg;
    logic [ROOT_W:0]     pden_reg;
    logic [ROOT_W-1:0]   par1_reg, ang1_reg;
    logic [PSUM_W-1:0]   psum;
    sd_div_t             perp_s [ROOT_W+1];
    sd_div_t             perp_in_reg;
    sd_side_t            side_reg [ROOT_W+1];
    logic [ROOT_W-1:0]   perp;

    logic [LAT_MID-1:0]  vld_line_reg;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wperp_reg <= WEIGHT_RESET;
            wpar_reg  <= WEIGHT_RESET;
            wang_reg  <= WEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WPERP: wperp_reg <= pwdata[WEIGHT_W-1:0];
                REG_WPAR:  wpar_reg  <= pwdata[WEIGHT_W-1:0];
                REG_WANG:  wang_reg  <= pwdata[WEIGHT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WPERP: prdata = DATA_W'(wperp_reg);
            REG_WPAR:  prdata = DATA_W'(wpar_reg);
            REG_WANG:  prdata = DATA_W'(wang_reg);
            default:   prdata = '0;
        endcase
    end

    sd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (start & ~busy),
        .seg_a_start_x (seg_a_start_x),
        .seg_a_start_y (seg_a_start_y),
        .seg_a_end_x   (seg_a_end_x),
        .seg_a_end_y   (seg_a_end_y),
        .seg_b_start_x (seg_b_start_x),
        .seg_b_start_y (seg_b_start_y),
        .seg_b_end_x   (seg_b_end_x),
        .seg_b_end_y   (seg_b_end_y),
        .out_vld       (front_vld),
        .lane_o        (front_lane)
    );

    // lanes: 0 = da, 1 = db, 2 = parallel, 3 = angle
    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        assign div_s[l][0] = front_lane[l];
        for (genvar k = 0; k < QUO_W; k++)
        begin : g_div
            sd_div_cell u_cell (
                .clk  (clk),
                .din  (div_s[l][k]),
                .dout (div_s[l][k+1])
            );
        end
        assign sq_s[l][0] = '{rem: '0, root: '0, sh: div_s[l][QUO_W].sh};
        for (genvar k = 0; k < ROOT_W; k++)
        begin : g_sqrt
            sd_sqrt_cell u_cell (
                .clk  (clk),
                .din  (sq_s[l][k]),
                .dout (sq_s[l][k+1])
            );
        end
    end

    assign da   = sq_s[0][ROOT_W].root;
    assign db   = sq_s[1][ROOT_W].root;
    assign psum = {1'b0, da2_reg} + {1'b0, db2_reg};

    // perpendicular term: (da^2 + db^2) / (da + db), quotient below 2^ROOT_W
    always_ff @(posedge clk)
    begin
        da2_reg  <= da * da;
        db2_reg  <= db * db;
        pden_reg <= {1'b0, da} + {1'b0, db};
        par1_reg <= sq_s[2][ROOT_W].root;
        ang1_reg <= sq_s[3][ROOT_W].root;

        perp_in_reg.rem <= DREM_W'(psum[PSUM_W-1:ROOT_W]);
        perp_in_reg.den <= DREM_W'(pden_reg);
        perp_in_reg.sh  <= QUO_W'(psum[ROOT_W-1:0]) << (QUO_W - ROOT_W);
        side_reg[0]     <= '{par: par1_reg, ang: ang1_reg, zero: pden_reg == '0};
        for (int k = 1; k <= ROOT_W; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign perp_s[0] = perp_in_reg;
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_perp
        sd_div_cell u_cell (
            .clk  (clk),
            .din  (perp_s[k]),
            .dout (perp_s[k+1])
        );
    end

    assign perp = side_reg[ROOT_W].zero ? '0 : perp_s[ROOT_W].sh[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_line_reg <= '0;
        end
        else
        begin
            vld_line_reg <= {vld_line_reg[LAT_MID-2:0], front_vld};
        end
    end

    sd_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (vld_line_reg[LAT_MID-1]),
        .perp      (perp),
        .par       (side_reg[ROOT_W].par),
        .ang       (side_reg[ROOT_W].ang),
        .w_perp    (wperp_reg),
        .w_par     (wpar_reg),
        .w_ang     (wang_reg),
        .done      (done),
        .distance  (distance),
        .saturated (saturated)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - segment_distance_core testbench
// Streams segment pairs through the kernel with random gaps, predicts each
// weighted distance in exact integer arithmetic and checks every result word.
// The weights are rewritten over APB between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb;

    import sd_pkg::*;

    localparam int PIPE_LAT = 7 + QUO_W + 2 * ROOT_W + 4;

    typedef struct {
        logic [IN_W-1:0] c [8];   // ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
    } seg_pair_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        logic              sat;
    } dist_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [IN_W-1:0]     pin [8];
    logic                done;
    logic [DIST_W-1:0]   distance;
    logic                saturated;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    seg_pair_t  pair_q [$];
    dist_word_t dist_q [$];
    logic [WEIGHT_W-1:0] w_perp = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_par  = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_ang  = WEIGHT_RESET;

    int  n_err = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_degen = 0;
    int  gap = 0;
    bit  burst = 1'b0;
    bit  took = 1'b0;

    initial begin
        for (int i = 0; i < 8; i++) pin[i] = '0;
    end

    always #5 clk = ~clk;

    segment_distance_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seg_a_start_x(pin[0]), .seg_a_start_y(pin[1]),
        .seg_a_end_x(pin[2]), .seg_a_end_y(pin[3]),
        .seg_b_start_x(pin[4]), .seg_b_start_y(pin[5]),
        .seg_b_end_x(pin[6]), .seg_b_end_y(pin[7]),
        .done(done), .distance(distance), .saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) r = c[63:0];
        end
        return r;
    endfunction

    // floor(sqrt(num^2 / den) * 2^FRAC_W)
    function automatic logic [63:0] scaled_len(logic [63:0] num, logic [63:0] den);
        logic [127:0] n;
        n = num;
        n = (n * n) << (2 * FRAC_W);
        return root_floor(n / den);
    endfunction

    function automatic logic [63:0] absval(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic dist_word_t seg_distance(seg_pair_t p);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint dx, dy, w1x, w1y, w2x, w2y, l2, dot1, dot2, vx, vy, v2;
        logic [63:0]  da, db, m, t, perp, par, ang;
        logic [127:0] num, total;
        dist_word_t   r;
        ax0 = longint'($signed(p.c[0])); ay0 = longint'($signed(p.c[1]));
        ax1 = longint'($signed(p.c[2])); ay1 = longint'($signed(p.c[3]));
        bx0 = longint'($signed(p.c[4])); by0 = longint'($signed(p.c[5]));
        bx1 = longint'($signed(p.c[6])); by1 = longint'($signed(p.c[7]));
        dx = ax1 - ax0; dy = ay1 - ay0;
        w1x = bx0 - ax0; w1y = by0 - ay0; w2x = bx1 - ax0; w2y = by1 - ay0;
        l2 = dx * dx + dy * dy;
        perp = 0; par = 0; ang = 0;
        if (l2 == 0) begin
            // A is a point: plain distances from its start
            num = 128'(w1x * w1x + w1y * w1y);
            da = root_floor(num << (2 * FRAC_W));
            num = 128'(w2x * w2x + w2y * w2y);
            db = root_floor(num << (2 * FRAC_W));
        end else begin
            dot1 = w1x * dx + w1y * dy;
            dot2 = w2x * dx + w2y * dy;
            vx = bx1 - bx0; vy = by1 - by0;
            v2 = vx * vx + vy * vy;
            m = absval(dot1);
            t = absval(l2 - dot1); if (t < m) m = t;
            t = absval(dot2);      if (t < m) m = t;
            t = absval(l2 - dot2); if (t < m) m = t;
            da  = scaled_len(absval(w1x * dy - w1y * dx), 64'(l2));
            db  = scaled_len(absval(w2x * dy - w2y * dx), 64'(l2));
            par = scaled_len(m, 64'(l2));
            if (v2 == 0) ang = root_floor(128'(l2) << (2 * FRAC_W));
            else         ang = scaled_len(absval(dx * vy - dy * vx), 64'(v2));
        end
        if (da + db != 0) begin
            num  = 128'(da) * 128'(da) + 128'(db) * 128'(db);
            perp = 64'(num / 128'(da + db));
        end
        total = (128'(w_perp) * perp + 128'(w_par) * par + 128'(w_ang) * ang)
                >> WEIGHT_FRAC;
        r.sat      = total > 128'(DIST_MAX);
        r.dist_val = r.sat ? DIST_MAX : total[DIST_W-1:0];
        return r;
    endfunction

    // driver: one pair per start, gap drawn per word
    always @(negedge clk) begin
        seg_pair_t p;
        if (rst_n && !(start && !took)) begin
            if (gap > 0) begin
                start <= 1'b0;
                gap <= gap - 1;
            end else if (pair_q.size() > 0) begin
                p = pair_q.pop_front();
                for (int i = 0; i < 8; i++) pin[i] <= p.c[i];
                start <= 1'b1;
                if ($urandom_range(0, 99) == 0) burst = ~burst;
                gap <= burst ? 0 : $urandom_range(0, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results first, then the word accepted at this edge
    always @(posedge clk) begin
        dist_word_t e;
        seg_pair_t  p;
        took <= start && !busy;
        if (rst_n && done) begin
            if (dist_q.size() == 0) begin
                $display("%0t: result with nothing expected: distance %0h sat %0b",
                         $time, distance, saturated);
                n_err++;
            end else begin
                e = dist_q.pop_front();
                n_checked++;
                if (distance !== e.dist_val) begin
                    $display("%0t: distance expected %0h actual %0h", $time, e.dist_val,
                             distance);
                    n_err++;
                end
                if (saturated !== e.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                             saturated);
                    n_err++;
                end
            end
        end
        if (rst_n && start && !busy) begin
            for (int i = 0; i < 8; i++) p.c[i] = pin[i];
            if (p.c[0] == p.c[2] && p.c[1] == p.c[3]) n_degen++;
            dist_q.push_back(seg_distance(p));
            n_sent++;
        end
    end

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] v);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx); pwdata <= DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WPERP: w_perp = v;
            REG_WPAR:  w_par  = v;
            default:   w_ang  = v;
        endcase
    endtask

    task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.c[0] = IN_W'(ax0); p.c[1] = IN_W'(ay0);
        p.c[2] = IN_W'(ax1); p.c[3] = IN_W'(ay1);
        p.c[4] = IN_W'(bx0); p.c[5] = IN_W'(by0);
        p.c[6] = IN_W'(bx1); p.c[7] = IN_W'(by1);
        pair_q.push_back(p);
    endtask

    function automatic int rnd_coord(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    task automatic add_random(int count);
        int k, ax0, ay0, dx, dy, s;
        int c [8];
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++) c[i] = $urandom_range(0, 65535) - 32768;
            case (k)
                0, 1: ;                                   // full range
                2: for (int i = 0; i < 8; i++) c[i] = rnd_coord(64);
                3: begin c[2] = c[0]; c[3] = c[1]; end    // A is a point
                4: begin c[6] = c[4]; c[7] = c[5]; end    // B is a point
                5: begin                                  // B on A's line
                    ax0 = rnd_coord(1000); ay0 = rnd_coord(1000);
                    dx = rnd_coord(100); dy = rnd_coord(100);
                    s = rnd_coord(20);
                    c[0] = ax0; c[1] = ay0; c[2] = ax0 + dx; c[3] = ay0 + dy;
                    c[4] = ax0 + s * dx; c[5] = ay0 + s * dy;
                    s = rnd_coord(20);
                    c[6] = ax0 + s * dx; c[7] = ay0 + s * dy;
                end
                6: for (int i = 0; i < 8; i++)
                    c[i] = $urandom_range(0, 1) ? -32768 : 32767;
                7: begin c[2] = c[0]; c[3] = c[1]; c[6] = c[4]; c[7] = c[5]; end
                default: for (int i = 0; i < 8; i++) c[i] = rnd_coord(4000);
            endcase
            add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
    endtask

    task automatic drain();
        wait (pair_q.size() == 0 && !start && dist_q.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, degenerate segments, collinear B
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 3, 4, -3, -4);
        add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
        add_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
        add_pair(0, 0, 10, 0, 5, 5, 5, 5);
        add_pair(-32768, 0, 32767, 0, 0, 32767, 0, 32767);
        add_pair(0, 0, 10, 0, 2, 0, 8, 0);
        add_pair(0, 0, 10, 0, -20, 0, 30, 0);
        add_pair(0, 0, 1, 1, 5, 5, -5, -5);
        add_pair(0, 0, 10, 0, 0, 3, 10, 3);
        add_pair(0, 0, 10, 0, 0, 0, 0, 10);
        add_pair(1, 2, 3, 4, -5, 7, 11, -13);
        add_pair(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
        add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
        add_pair(0, -32768, 0, 32767, 32767, 0, -32768, 0);
        add_random(330);
        drain();

        reg_write(REG_WPERP, 16'hffff);
        reg_write(REG_WPAR, 16'hffff);
        reg_write(REG_WANG, 16'hffff);
        add_random(350);
        drain();

        reg_write(REG_WPERP, 16'h0000);
        reg_write(REG_WPAR, 16'h0000);
        reg_write(REG_WANG, 16'h0000);
        add_random(100);
        drain();

        reg_write(REG_WPERP, 16'h0001);
        reg_write(REG_WPAR, 16'h8000);
        reg_write(REG_WANG, 16'h0000);
        add_random(300);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            reg_write(REG_WPERP, 16'($urandom_range(0, 65535)));
            reg_write(REG_WPAR, 16'($urandom_range(0, 65535)));
            reg_write(REG_WANG, 16'($urandom_range(0, 65535)));
            add_random(220);
            drain();
        end

        if (dist_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, dist_q.size());
            n_err++;
        end
        $display("%0d segment pairs sent (%0d with A a point), %0d results checked,",
                 n_sent, n_degen, n_checked);
        $display("over seven weight settings including all-zero and all-max");
        if (n_err == 0)
            $display("** segment_distance_core: PASSED **");
        else
            $display("** segment_distance_core: FAILED **");
        $finish;
    end

    initial begin
        #3000000;
        $display("%0t: timeout", $time);
        $display("** segment_distance_core: FAILED **");
        $finish;
    end

endmodule
